// File: design/qph_pkg.sv
`timescale 1ns / 1ps

package qph_pkg;

  localparam int TableSizeDef = 31;
  localparam int HashModDef   = 31;
  localparam int KeyW         = 31;

  typedef enum logic {
    OpInsert = 1'b0,
    OpSearch = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StFull     = 2'd1,
    StNoFree   = 2'd2,
    StNotFound = 2'd3
  } status_e;

  typedef struct packed {
    logic            start;
    logic [KeyW-1:0] key;
  } hash_req_t;

endpackage

// File: design/qph_req_if.sv
`timescale 1ns / 1ps

interface qph_req_if;
  logic                     valid;
  logic                     ready;
  qph_pkg::op_e             operation;
  logic [qph_pkg::KeyW-1:0] key;

  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);
endinterface

// File: design/qph_rsp_if.sv
`timescale 1ns / 1ps

interface qph_rsp_if #(
  parameter int SlotW = $clog2(qph_pkg::TableSizeDef)
);
  logic               valid;
  logic               ready;
  qph_pkg::status_e   result_status;
  logic [SlotW-1:0]   slot;

  modport source (output valid, output result_status, output slot, input ready);
  modport sink   (input valid, input result_status, input slot, output ready);
endinterface

// File: design/quadratic_probe_hash_table_top.sv
`timescale 1ns / 1ps
// a full-table insert answers without hashing or probing; any other item answers
// after the hash and at most TableSize probes
// one item at a time: serial hash division, 4 bits per cycle, then one
// probe per cycle through the single read port of the key memory; the next item is
// taken only once the last result is loaded into the output register, which a stall holds off
// reset: a clearing pass writes every slot empty, no items taken

module quadratic_probe_hash_table_top #(
  parameter int TableSize   = qph_pkg::TableSizeDef,
  parameter int HashModulus = qph_pkg::HashModDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  qph_req_if.sink        req_i,
  qph_rsp_if.source      rsp_o
);

  localparam int SlotW = $clog2(TableSize);
  localparam int CntW  = $clog2(TableSize + 1);
  localparam int KeyW  = qph_pkg::KeyW;

  localparam logic [2:0] SClear = 3'd0;
  localparam logic [2:0] SIdle  = 3'd1;
  localparam logic [2:0] SHash  = 3'd2;
  localparam logic [2:0] SProbe = 3'd3;
  localparam logic [2:0] SResp  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [SlotW-1:0]  clr_q, clr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   iss_q, iss_d;
  logic              rd_vld_q, rd_vld_d;
  logic              rd_last_q, rd_last_d;
  logic              out_vld_q, out_vld_d;

  qph_pkg::op_e      op_q, op_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [SlotW-1:0]  p_q, p_d, d_q, d_d, p_nx, d_nx;
  logic [SlotW-1:0]  rd_slot_q, rd_slot_d;
  qph_pkg::status_e  res_st_q, res_st_d, out_st_q, out_st_d;
  logic [SlotW-1:0]  res_slot_q, res_slot_d, out_slot_q, out_slot_d;
  logic [SlotW:0]    p_sum, d_sum;

  logic              accept, full;
  logic              ram_we;
  logic [SlotW-1:0]  ram_waddr;
  logic [KeyW:0]     ram_wdata, ram_rdata;
  logic              occ, hit;

  qph_pkg::hash_req_t hash_req;
  logic               hash_done;
  logic [SlotW-1:0]   hash_home;

  assign req_i.ready = (state_q == SIdle);
  assign accept      = req_i.valid && req_i.ready;
  assign full        = (cnt_q >= CntW'(TableSize));

  assign hash_req.start = accept && !(req_i.operation == qph_pkg::OpInsert && full);
  assign hash_req.key   = req_i.key;

  qph_hash #(
    .TableSize   (TableSize),
    .HashModulus (HashModulus)
  ) u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hash_req),
    .done_o (hash_done),
    .home_o (hash_home)
  );

  qph_ram #(
    .Width (KeyW + 1),
    .Depth (TableSize)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (p_q),
    .rdata_o (ram_rdata)
  );

  // next probe: offset grows by 2i+1 each step
  always_comb begin
    p_sum = {1'b0, p_q} + {1'b0, d_q};
    p_nx  = (p_sum >= (SlotW+1)'(TableSize)) ?
            SlotW'(p_sum - (SlotW+1)'(TableSize)) : p_sum[SlotW-1:0];
    d_sum = {1'b0, d_q} + (SlotW+1)'(2);
    d_nx  = (d_sum >= (SlotW+1)'(TableSize)) ?
            SlotW'(d_sum - (SlotW+1)'(TableSize)) : d_sum[SlotW-1:0];
  end

  assign occ = ram_rdata[KeyW];
  assign hit = (ram_rdata[KeyW-1:0] == key_q);

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    cnt_d      = cnt_q;
    iss_d      = iss_q;
    rd_vld_d   = 1'b0;
    rd_last_d  = rd_last_q;
    rd_slot_d  = rd_slot_q;
    op_d       = op_q;
    key_d      = key_q;
    p_d        = p_q;
    d_d        = d_q;
    res_st_d   = res_st_q;
    res_slot_d = res_slot_q;
    out_vld_d  = out_vld_q && !rsp_o.ready;
    out_st_d   = out_st_q;
    out_slot_d = out_slot_q;
    ram_we     = 1'b0;
    ram_waddr  = rd_slot_q;
    ram_wdata  = {1'b1, key_q};

    unique case (state_q)
      SClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + SlotW'(1);
        if (clr_q == SlotW'(TableSize - 1)) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (accept) begin
          op_d  = req_i.operation;
          key_d = req_i.key;
          if (req_i.operation == qph_pkg::OpInsert && full) begin
            res_st_d   = qph_pkg::StFull;
            res_slot_d = '0;
            state_d    = SResp;
          end else begin
            state_d = SHash;
          end
        end
      end
      SHash: begin
        if (hash_done) begin
          p_d     = hash_home;
          d_d     = SlotW'(1);
          iss_d   = '0;
          state_d = SProbe;
        end
      end
      SProbe: begin
        if (iss_q < CntW'(TableSize)) begin
          rd_vld_d  = 1'b1;
          rd_slot_d = p_q;
          rd_last_d = (iss_q == CntW'(TableSize - 1));
          p_d       = p_nx;
          d_d       = d_nx;
          iss_d     = iss_q + CntW'(1);
        end
        if (rd_vld_q) begin
          if (op_q == qph_pkg::OpInsert) begin
            if (!occ) begin
              ram_we     = 1'b1;
              cnt_d      = cnt_q + CntW'(1);
              res_st_d   = qph_pkg::StOk;
              res_slot_d = rd_slot_q;
              rd_vld_d   = 1'b0;
              state_d    = SResp;
            end else if (rd_last_q) begin
              res_st_d   = qph_pkg::StNoFree;
              res_slot_d = '0;
              rd_vld_d   = 1'b0;
              state_d    = SResp;
            end
          end else begin
            if (!occ || (rd_last_q && !hit)) begin
              res_st_d   = qph_pkg::StNotFound;
              res_slot_d = '0;
              rd_vld_d   = 1'b0;
              state_d    = SResp;
            end else if (hit) begin
              res_st_d   = qph_pkg::StOk;
              res_slot_d = rd_slot_q;
              rd_vld_d   = 1'b0;
              state_d    = SResp;
            end
          end
        end
      end
      SResp: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d  = 1'b1;
          out_st_d   = res_st_q;
          out_slot_d = res_slot_q;
          state_d    = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SClear;
      clr_q     <= '0;
      cnt_q     <= '0;
      iss_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      cnt_q     <= cnt_d;
      iss_q     <= iss_d;
      rd_vld_q  <= rd_vld_d;
      rd_last_q <= rd_last_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    p_q        <= p_d;
    d_q        <= d_d;
    rd_slot_q  <= rd_slot_d;
    res_st_q   <= res_st_d;
    res_slot_q <= res_slot_d;
    out_st_q   <= out_st_d;
    out_slot_q <= out_slot_d;
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.result_status = out_st_q;
  assign rsp_o.slot          = out_slot_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(TableSize))
    else $error("entry count above table size");

  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_st_q != qph_pkg::StOk) |-> (out_slot_q == '0))
    else $error("slot not zero on failed item");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == SClear || state_q == SProbe))
    else $error("key memory written outside clear or probe");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SProbe && ram_we) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("insert did not count the entry");

endmodule

// File: design/qph_ram.sv
`timescale 1ns / 1ps

module qph_ram #(
  parameter int Width = 32,
  parameter int Depth = 31
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/qph_hash.sv
`timescale 1ns / 1ps

module qph_hash #(
  parameter int TableSize   = qph_pkg::TableSizeDef,
  parameter int HashModulus = qph_pkg::HashModDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  qph_pkg::hash_req_t           req_i,
  output logic                         done_o,
  output logic [$clog2(TableSize)-1:0] home_o
);

  localparam int SlotW     = $clog2(TableSize);
  localparam int HmW       = $clog2(HashModulus + 1);
  localparam int TsW       = $clog2(TableSize + 1);
  localparam int RemW      = (HmW > TsW) ? HmW : TsW;
  localparam int ShW       = qph_pkg::KeyW + 1;
  localparam int DigitBits = 4;
  localparam int Ph1Steps  = ShW / DigitBits;
  localparam int Ph2Steps  = (RemW + DigitBits - 1) / DigitBits;
  localparam int StepW     = $clog2(Ph1Steps + 1);

  localparam logic [1:0] HIdle = 2'd0;
  localparam logic [1:0] HMod1 = 2'd1;
  localparam logic [1:0] HMod2 = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [ShW-1:0]   sh_q, sh_d, sh_n;
  logic [RemW-1:0]  rem_q, rem_d, rem_n;
  logic [SlotW-1:0] home_q, home_d;
  logic [RemW:0]    div, t;

  // restoring remainder, one digit per cycle
  always_comb begin
    div  = (state_q == HMod1) ? (RemW+1)'(HashModulus) : (RemW+1)'(TableSize);
    rem_n = rem_q;
    sh_n  = sh_q;
    t     = '0;
    for (int k = 0; k < DigitBits; k++) begin
      t    = {rem_n, sh_n[ShW-1]};
      sh_n = sh_n << 1;
      if (t >= div) begin
        t = t - div;
      end
      rem_n = t[RemW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    sh_d    = sh_q;
    rem_d   = rem_q;
    home_d  = home_q;
    unique case (state_q)
      HIdle: begin
        if (req_i.start) begin
          sh_d    = {1'b0, req_i.key};
          rem_d   = '0;
          cnt_d   = '0;
          state_d = HMod1;
        end
      end
      HMod1: begin
        sh_d  = sh_n;
        rem_d = rem_n;
        cnt_d = cnt_q + StepW'(1);
        if (cnt_q == StepW'(Ph1Steps - 1)) begin
          sh_d    = ShW'(rem_n) << (ShW - DigitBits * Ph2Steps);
          rem_d   = '0;
          cnt_d   = '0;
          state_d = HMod2;
        end
      end
      HMod2: begin
        sh_d  = sh_n;
        rem_d = rem_n;
        cnt_d = cnt_q + StepW'(1);
        if (cnt_q == StepW'(Ph2Steps - 1)) begin
          done_d  = 1'b1;
          home_d  = rem_n[SlotW-1:0];
          state_d = HIdle;
        end
      end
      default: state_d = HIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    rem_q  <= rem_d;
    home_q <= home_d;
  end

  assign done_o = done_q;
  assign home_o = home_q;

  a_home_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (32'(home_q) < TableSize))
    else $error("home slot out of range");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  import qph_pkg::*;

  localparam int          Slots      = TableSizeDef;
  localparam int          HashMod    = HashModDef;
  localparam int          RandItems  = 1800;
  localparam int          CalmTail   = 200;
  localparam int          PauseAt    = 700;
  localparam int          HoldAt     = 400;
  localparam int          HoldCycles = 300;
  localparam int          DrainWait  = 60;
  localparam int          IdleLimit  = 2000;
  localparam logic [30:0] KeyMax     = 31'h7fff_ffff;

  typedef struct packed {
    status_e    status;
    logic [4:0] slot;
  } probe_result_t;

  typedef struct {
    op_e           op;
    logic [30:0]   key;
    bit            typed;
    probe_result_t res;
  } stim_row_t;

  logic clk   = 1'b0;
  logic rst_n;

  qph_req_if             req ();
  qph_rsp_if #(.SlotW(5)) rsp ();

  quadratic_probe_hash_table_top u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always #4 clk = ~clk;

  logic [30:0]   slot_key_copy [Slots];
  bit            slot_used_copy[Slots];
  int unsigned   entry_total;
  logic [30:0]   stored_keys[$];
  probe_result_t pending_results[$];
  int            mismatch_count;
  bit            idling_on;

  function automatic probe_result_t predict_probe(op_e op, logic [30:0] key);
    probe_result_t res;
    int unsigned   home;
    int unsigned   pos;
    res  = '{StNotFound, 5'd0};
    home = (32'(key) % HashMod) % Slots;
    if (op == OpInsert) begin
      if (entry_total >= Slots) begin
        res.status = StFull;
      end else begin
        res.status = StNoFree;
        for (int unsigned i = 0; i < Slots; i++) begin
          pos = (home + i * i) % Slots;
          if (!slot_used_copy[pos]) begin
            slot_key_copy[pos]  = key;
            slot_used_copy[pos] = 1'b1;
            entry_total++;
            stored_keys.push_back(key);
            res = '{StOk, 5'(pos)};
            break;
          end
        end
      end
    end else begin
      for (int unsigned i = 0; i < Slots; i++) begin
        pos = (home + i * i) % Slots;
        if (!slot_used_copy[pos]) break;
        if (slot_key_copy[pos] == key) begin
          res = '{StOk, 5'(pos)};
          break;
        end
      end
    end
    return res;
  endfunction

  task automatic send_item(op_e op, logic [30:0] key, bit typed, probe_result_t typed_res,
                           bit may_idle);
    probe_result_t model_res;
    req.valid     <= 1'b1;
    req.operation <= op;
    req.key       <= key;
    do @(posedge clk); while (req.ready !== 1'b1);
    model_res = predict_probe(op, key);
    pending_results.push_back(typed ? typed_res : model_res);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // stimulus
  initial begin : drive_requests
    stim_row_t   rows[$];
    op_e         op;
    logic [30:0] key;
    req.valid      <= 1'b0;
    req.operation  <= OpInsert;
    req.key        <= '0;
    rst_n          <= 1'b0;
    entry_total    = 0;
    mismatch_count = 0;
    idling_on      = 1'b1;
    foreach (slot_used_copy[s]) slot_used_copy[s] = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    rows.push_back('{OpSearch, 31'd0,   1'b1, '{StNotFound, 5'd0}});
    rows.push_back('{OpInsert, 31'd0,   1'b1, '{StOk, 5'd0}});
    rows.push_back('{OpInsert, KeyMax,  1'b1, '{StOk, 5'd1}});
    rows.push_back('{OpSearch, KeyMax,  1'b1, '{StOk, 5'd1}});
    // duplicate key lands further down the path, search still hits the first copy
    rows.push_back('{OpInsert, 31'd0,   1'b0, '{StOk, 5'd0}});
    rows.push_back('{OpSearch, 31'd0,   1'b1, '{StOk, 5'd0}});
    rows.push_back('{OpSearch, 31'd31,  1'b0, '{StOk, 5'd0}});
    // fill the whole home-zero probe path
    for (int k = 1; k <= 13; k++) begin
      rows.push_back('{OpInsert, 31'(31 * k), 1'b0, '{StOk, 5'd0}});
    end
    rows.push_back('{OpInsert, 31'(31 * 14), 1'b1, '{StNoFree, 5'd0}});
    rows.push_back('{OpSearch, 31'(31 * 13), 1'b0, '{StOk, 5'd0}});
    rows.push_back('{OpSearch, 31'(31 * 99), 1'b1, '{StNotFound, 5'd0}});
    rows.push_back('{OpInsert, 31'h2aaa_aaaa, 1'b0, '{StOk, 5'd0}});
    rows.push_back('{OpSearch, 31'h5555_5555, 1'b0, '{StOk, 5'd0}});

    foreach (rows[r]) begin
      send_item(rows[r].op, rows[r].key, rows[r].typed, rows[r].res, 1'b1);
    end

    for (int n = 0; n < RandItems; n++) begin
      idling_on = (n < RandItems - CalmTail) && ((n / 120) % 3 != 1);
      if (n == PauseAt) begin
        req.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      op = ($urandom_range(0, 99) < ((entry_total < Slots) ? 35 : 15)) ? OpInsert : OpSearch;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          if (stored_keys.size() != 0) begin
            key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
          end else begin
            key = 31'($urandom());
          end
        end
        4, 5: key = 31'($urandom_range(0, 30) + 31 * $urandom_range(0, 69273665));
        6: key = 31'($urandom_range(0, 63));
        7: begin
          case ($urandom_range(0, 3))
            0: key = 31'd0;
            1: key = KeyMax;
            2: key = KeyMax - 31'd1;
            default: key = 31'd31;
          endcase
        end
        default: key = 31'($urandom());
      endcase
      send_item(op, key, 1'b0, '{StOk, 5'd0}, idling_on);
    end

    req.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (DrainWait) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // result side: random back-pressure and one long hold-off
  initial begin : take_results
    int            stall_left;
    int            results_seen;
    bit            held;
    probe_result_t want;
    stall_left   = 0;
    results_seen = 0;
    held         = 1'b0;
    rsp.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected item, got status %s slot %0d", $time,
                   rsp.result_status.name(), rsp.slot);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (rsp.result_status !== want.status) begin
            $display("%0t: status mismatch, expected %s, got %s", $time,
                     want.status.name(), rsp.result_status.name());
            mismatch_count++;
          end
          if (rsp.slot !== want.slot) begin
            $display("%0t: slot mismatch, expected %0d, got %0d", $time, want.slot, rsp.slot);
            mismatch_count++;
          end
        end
      end
      if (!held && results_seen >= HoldAt) begin
        held       = 1'b1;
        stall_left = HoldCycles;
      end else if (stall_left == 0 && idling_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9);
      end
      if (stall_left > 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req.valid === 1'b1 && req.ready === 1'b1) ||
          (rsp.valid === 1'b1 && rsp.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, IdleLimit);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

endmodule
